>>> rtl/swcg_pkg.sv
// Shared types, constants and the cosine table builder for the window generator.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package swcg_pkg;

    typedef enum logic [1:0] {
        WIN_RECT     = 2'd0,
        WIN_HANN     = 2'd1,
        WIN_HAMMING  = 2'd2,
        WIN_BLACKMAN = 2'd3
    } window_type_t;

    localparam int REG_TYPE   = 0;
    localparam int REG_LENGTH = 1;

    localparam int LEN_W   = 17;
    localparam int COEF_W  = 17;
    localparam int COS_W   = 18;
    localparam int PROD_W  = 36;
    localparam int QUOT_W  = 17;

    localparam logic [LEN_W-1:0] LEN_RESET = 17'd1024;
    localparam logic [COEF_W-1:0] COEF_ONE = 17'd65536;

    // Q16 window constants
    localparam logic [15:0] K_HALF = 16'd32768;
    localparam logic [15:0] K_054  = 16'd35389;
    localparam logic [15:0] K_046  = 16'd30147;
    localparam logic [15:0] K_042  = 16'd27525;
    localparam logic [15:0] K_008  = 16'd5243;

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // Quarter-wave cosine entry k of a table of Depth steps, Q16, elaboration only
    function automatic longint quarter_cos(input longint k, input longint Depth);
        longint x;
        longint x2;
        longint t;
        longint m;
        longint r;
        x = (k * HALF_PI_Q30) / Depth;
        x2 = (x * x) / Q30_ONE;
        t = Q30_ONE;
        for (int i = 8; i >= 1; i--)
        begin
            m = (x2 * t) / Q30_ONE;
            case (i)
                8: m = m / 240;
                7: m = m / 182;
                6: m = m / 132;
                5: m = m / 90;
                4: m = m / 56;
                3: m = m / 30;
                2: m = m / 12;
                default: m = m / 2;
            endcase
            t = Q30_ONE - m;
        end
        if (t < 0)
        begin
            t = 0;
        end
        r = (t + 8192) >>> 14;
        if (r > 65536)
        begin
            r = 65536;
        end
        return r;
    endfunction

endpackage

>>> rtl/swcg_phase_div.sv
// Pipelined restoring divider: phase = floor((n*65536 + floor(m/2)) / m).
// One quotient bit per stage, QUOT_W stages. Uses swcg_pkg.
`timescale 1ns / 1ps

module swcg_phase_div #(
    parameter int INDEX_BITS = 16
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [INDEX_BITS-1:0]        n,
    input  logic [swcg_pkg::LEN_W-1:0]   m,
    output logic [swcg_pkg::QUOT_W-1:0]  quot
);

    localparam int QW = swcg_pkg::QUOT_W;
    localparam int LW = swcg_pkg::LEN_W;
    localparam int DW = INDEX_BITS + 17;

    logic [DW-1:0] dividend;
    logic [LW-1:0] rem_reg [0:QW-1];
    logic [QW-1:0] q_reg   [0:QW-1];
    logic [QW-1:0] low_reg [0:QW-1];
    logic [LW-1:0] rem_init;
    logic [QW-1:0] low_init;

    assign dividend = DW'({n, 16'd0}) + DW'(m >> 1);
    assign rem_init = LW'(dividend >> QW);
    assign low_init = dividend[QW-1:0];

    for (genvar s = 0; s < QW; s++)
    begin : g_step
        logic [LW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] q_in;
        logic [LW:0]   trial;
        logic          ge;

        if (s == 0)
        begin : g_first
            assign rem_in = rem_init;
            assign low_in = low_init;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign low_in = low_reg[s-1];
            assign q_in   = q_reg[s-1];
        end

        assign trial = {rem_in, low_in[QW-1-s]};
        assign ge    = trial >= {1'b0, m};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= ge ? LW'(trial - {1'b0, m}) : trial[LW-1:0];
                q_reg[s]   <= {q_in[QW-2:0], ge};
                low_reg[s] <= low_in;
            end
        end
    end

    assign quot = q_reg[QW-1];

endmodule

>>> rtl/swcg_cos_rom.sv
// Quarter-wave cosine ROM, DEPTH+1 entries in Q16, registered read.
// Contents built at elaboration by swcg_pkg::quarter_cos.
`timescale 1ns / 1ps

module swcg_cos_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [$clog2(DEPTH+1)-1:0]    addr,
    output logic [swcg_pkg::COEF_W-1:0]   data
);

    logic [swcg_pkg::COEF_W-1:0] rom [0:DEPTH];
    logic [swcg_pkg::COEF_W-1:0] data_reg;

    for (genvar k = 0; k <= DEPTH; k++)
    begin : g_rom
        assign rom[k] = swcg_pkg::COEF_W'(swcg_pkg::quarter_cos(longint'(k), longint'(DEPTH)));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= rom[addr];
        end
    end

    assign data = data_reg;

endmodule

>>> rtl/swcg_cos_lookup.sv
// Cosine of a 16-bit turn fraction: quadrant split, nearest table entry, sign.
// Three register stages. Uses swcg_pkg and swcg_cos_rom.
`timescale 1ns / 1ps

module swcg_cos_lookup #(
    parameter int DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic [15:0]                        angle,
    output logic signed [swcg_pkg::COS_W-1:0]  cos_val
);

    localparam int IW = $clog2(DEPTH+1);
    localparam int PW = 14 + IW + 1;

    logic [PW-1:0] scaled;
    logic [IW-1:0] idx_reg;
    logic [1:0]    quad_reg;
    logic [1:0]    quad_b_reg;
    logic [IW-1:0] addr;
    logic [swcg_pkg::COEF_W-1:0] entry;
    logic signed [swcg_pkg::COS_W-1:0] cos_reg;

    assign scaled = PW'(angle[13:0]) * PW'(DEPTH) + PW'(8192);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_reg    <= IW'(scaled >> 14);
            quad_reg   <= angle[15:14];
            quad_b_reg <= quad_reg;
            if (quad_b_reg == 2'd1 || quad_b_reg == 2'd2)
            begin
                cos_reg <= -$signed({1'b0, entry});
            end
            else
            begin
                cos_reg <= $signed({1'b0, entry});
            end
        end
    end

    // odd quadrants mirror the table
    assign addr = quad_reg[0] ? IW'(DEPTH) - idx_reg : idx_reg;

    swcg_cos_rom #(.DEPTH(DEPTH)) u_rom (
        .clk  (clk),
        .en   (en),
        .addr (addr),
        .data (entry)
    );

    assign cos_val = cos_reg;

endmodule

>>> rtl/spectral_window_coefficient_generator.sv
// Top level of the window coefficient generator: config registers, pipeline control, mixing.
// Depends on swcg_pkg, swcg_phase_div, swcg_cos_lookup.
`timescale 1ns / 1ps

// Usage:
//   Program window_type (index 0) and window_length (index 1) through the
//   cfg_write / cfg_index / cfg_data port while no items are in flight.
//   Send sample indices on sample_valid / sample_stall / sample_index; each
//   transfer yields exactly one result on result_valid / result_stall with
//   coefficient (unsigned Q1.16) and index_out_of_range.
// Pipeline: 24 register stages. The stages are one input register, 17
//   divider stages (one phase bit per stage), three cosine lookup stages,
//   a multiply stage, a sum stage and the output register.
// Throughput: one item per cycle while the pipeline is not stalled; the pipeline is fully pipelined.
// Stall: the whole pipeline holds while a result waits under result_stall;
//   sample_stall is raised only then, so nothing is dropped or repeated.
// Reset: clears all valid bits; window_type returns to Hann and
//   window_length to 1024. The cosine table is a constant ROM and needs no
//   initialization pass.
module spectral_window_coefficient_generator #(
    parameter int INDEX_BITS      = 16,
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [swcg_pkg::LEN_W-1:0]    cfg_data,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [15:0]                   sample_index,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [swcg_pkg::COEF_W-1:0]   coefficient,
    output logic                          index_out_of_range
);

    localparam int LAT  = 24;
    localparam int LW   = swcg_pkg::LEN_W;
    localparam int CMPW = (INDEX_BITS > LW) ? INDEX_BITS : LW;
    localparam int PW   = swcg_pkg::PROD_W;

    swcg_pkg::window_type_t type_reg;
    logic [LW-1:0]          len_reg;

    logic                   en;
    logic [LAT-1:0]         vld_reg;
    logic [LAT-1:0]         oor_reg;
    logic [LAT-1:0]         one_reg;
    logic [INDEX_BITS-1:0]  n_reg;
    logic [INDEX_BITS-1:0]  n_next;
    logic                   oor_next;
    logic                   one_next;
    logic [LW-1:0]          m;
    logic [swcg_pkg::QUOT_W-1:0] phase;
    logic signed [swcg_pkg::COS_W-1:0] c1;
    logic signed [swcg_pkg::COS_W-1:0] c2;
    logic signed [PW-1:0]   p1_reg;
    logic signed [PW-1:0]   p2_reg;
    logic signed [PW-1:0]   v_reg;
    logic [15:0]            ka_reg;
    logic [15:0]            kb;
    logic [15:0]            kc;
    logic [PW-1:0]          v_clamp;
    logic [PW-1:0]          rounded;
    logic [swcg_pkg::COEF_W-1:0] coef_next;
    logic [swcg_pkg::COEF_W-1:0] coef_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg <= swcg_pkg::WIN_HANN;
            len_reg  <= swcg_pkg::LEN_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == 1'(swcg_pkg::REG_TYPE))
            begin
                type_reg <= swcg_pkg::window_type_t'(cfg_data[1:0]);
            end
            else
            begin
                len_reg <= cfg_data;
            end
        end
    end

    // Advance the whole pipe unless a finished result is held under stall
    assign en           = !(vld_reg[LAT-1] && result_stall);
    assign sample_stall = !en;

    assign n_next   = INDEX_BITS'(sample_index);
    assign oor_next = CMPW'(n_next) >= CMPW'(len_reg);
    assign one_next = (len_reg <= LW'(1)) || (type_reg == swcg_pkg::WIN_RECT);
    assign m        = len_reg - LW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], sample_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg   <= n_next;
            oor_reg <= {oor_reg[LAT-2:0], oor_next};
            one_reg <= {one_reg[LAT-2:0], one_next};
        end
    end

    swcg_phase_div #(.INDEX_BITS(INDEX_BITS)) u_div (
        .clk  (clk),
        .en   (en),
        .n    (n_reg),
        .m    (m),
        .quot (phase)
    );

    // cos(2 pi r) and cos(4 pi r)
    swcg_cos_lookup #(.DEPTH(COS_TABLE_DEPTH)) u_cos1 (
        .clk     (clk),
        .en      (en),
        .angle   (phase[15:0]),
        .cos_val (c1)
    );

    swcg_cos_lookup #(.DEPTH(COS_TABLE_DEPTH)) u_cos2 (
        .clk     (clk),
        .en      (en),
        .angle   ({phase[14:0], 1'b0}),
        .cos_val (c2)
    );

    always_comb
    begin
        case (type_reg)
            swcg_pkg::WIN_HAMMING:
            begin
                kb = swcg_pkg::K_046;
                kc = 16'd0;
            end
            swcg_pkg::WIN_BLACKMAN:
            begin
                kb = swcg_pkg::K_HALF;
                kc = swcg_pkg::K_008;
            end
            default:
            begin
                kb = swcg_pkg::K_HALF;
                kc = 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= $signed({1'b0, kb}) * PW'(c1);
            p2_reg <= $signed({1'b0, kc}) * PW'(c2);
            case (type_reg)
                swcg_pkg::WIN_HAMMING:  ka_reg <= swcg_pkg::K_054;
                swcg_pkg::WIN_BLACKMAN: ka_reg <= swcg_pkg::K_042;
                default:                ka_reg <= swcg_pkg::K_HALF;
            endcase
            v_reg <= $signed(PW'({ka_reg, 16'd0})) - p1_reg + p2_reg;
        end
    end

    // Clamp negatives, round to Q16, saturate at 1.0
    assign v_clamp = v_reg[PW-1] ? '0 : PW'(v_reg);
    assign rounded = (v_clamp + PW'(32768)) >> 16;

    always_comb
    begin
        if (oor_reg[LAT-2])
        begin
            coef_next = '0;
        end
        else if (one_reg[LAT-2] || rounded > PW'(swcg_pkg::COEF_ONE))
        begin
            coef_next = swcg_pkg::COEF_ONE;
        end
        else
        begin
            coef_next = rounded[swcg_pkg::COEF_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coef_reg <= coef_next;
        end
    end

    assign result_valid       = vld_reg[LAT-1];
    assign coefficient        = coef_reg;
    assign index_out_of_range = oor_reg[LAT-1];

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && index_out_of_range |-> coefficient == '0)
        else $error("out-of-range result carries nonzero coefficient");

    a_coef_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> coefficient <= swcg_pkg::COEF_ONE)
        else $error("coefficient above 1.0");

    a_rect_one: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !index_out_of_range && type_reg == swcg_pkg::WIN_RECT
        |-> coefficient == swcg_pkg::COEF_ONE)
        else $error("rectangular window gives other than 1.0");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

endmodule

>>> tb/swcg_checker.sv
// Scoreboard for the window coefficient generator: mirrors the register writes,
// predicts each result and compares it with what leaves the block. Uses swcg_pkg.
`timescale 1ns / 1ps

module swcg_checker #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [swcg_pkg::LEN_W-1:0]  cfg_data,
    input  logic                        sample_valid,
    input  logic                        sample_stall,
    input  logic [15:0]                 sample_index,
    input  logic                        result_valid,
    input  logic                        result_stall,
    input  logic [swcg_pkg::COEF_W-1:0] coefficient,
    input  logic                        index_out_of_range,
    output int                          failures,
    output int                          outstanding,
    output int                          checked,
    output int                          flagged
);

    typedef struct packed {
        logic [swcg_pkg::COEF_W-1:0] coef;
        logic                        oor;
    } coef_result_t;

    swcg_pkg::window_type_t      shape;
    logic [swcg_pkg::LEN_W-1:0]  points;
    longint                      cos_rom [0:TABLE_DEPTH];
    coef_result_t                coef_fifo [$];

    // Quarter-wave cosine in Q16 via a truncating Horner series in Q30
    function automatic longint rom_entry(input longint k);
        longint x;
        longint x2;
        longint t;
        longint r;
        x = (k * 64'sd1686629713) / TABLE_DEPTH;
        x2 = (x * x) / (64'sd1 << 30);
        t = 64'sd1 << 30;
        for (int i = 8; i >= 1; i--)
        begin
            t = (64'sd1 << 30) - ((x2 * t) / (64'sd1 << 30)) / (longint'(2 * i) * (2 * i - 1));
        end
        if (t < 0)
        begin
            t = 0;
        end
        r = (t + 8192) >>> 14;
        return (r > 65536) ? 65536 : r;
    endfunction

    function automatic longint cos_of_turn(input logic [15:0] a);
        logic [1:0] q;
        longint     idx;
        longint     mir;
        q = a[15:14];
        idx = (longint'(a[13:0]) * TABLE_DEPTH + 8192) / 16384;
        if (idx > TABLE_DEPTH)
        begin
            idx = TABLE_DEPTH;
        end
        mir = TABLE_DEPTH - idx;
        case (q)
            2'd0: return cos_rom[idx];
            2'd1: return -cos_rom[mir];
            2'd2: return -cos_rom[idx];
            default: return cos_rom[mir];
        endcase
    endfunction

    function automatic coef_result_t window_coef(input logic [15:0] n);
        coef_result_t res;
        longint       m;
        longint       p;
        longint       c1;
        longint       c2;
        longint       v;
        longint       w;
        res = '0;
        if (longint'(n) >= longint'(points))
        begin
            res.oor = 1'b1;
            return res;
        end
        if (points <= 1 || shape == swcg_pkg::WIN_RECT)
        begin
            res.coef = swcg_pkg::COEF_ONE;
            return res;
        end
        m = longint'(points) - 1;
        p = (longint'(n) * 65536 + m / 2) / m;
        c1 = cos_of_turn(p[15:0]);
        c2 = cos_of_turn(16'(2 * p));
        case (shape)
            swcg_pkg::WIN_HANN: v = 64'sd32768 * 65536 - 64'sd32768 * c1;
            swcg_pkg::WIN_HAMMING: v = 64'sd35389 * 65536 - 64'sd30147 * c1;
            default: v = 64'sd27525 * 65536 - 64'sd32768 * c1 + 64'sd5243 * c2;
        endcase
        if (v < 0)
        begin
            v = 0;   // Blackman dips just below zero near the ends
        end
        w = (v + 32768) >>> 16;
        res.coef = (w > 65536) ? swcg_pkg::COEF_ONE : swcg_pkg::COEF_W'(w);
        return res;
    endfunction

    initial
    begin
        for (int k = 0; k <= TABLE_DEPTH; k++)
        begin
            cos_rom[k] = rom_entry(k);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        coef_result_t want;
        int           errs;
        errs = 0;
        if (!rst_n)
        begin
            shape <= swcg_pkg::WIN_HANN;
            points <= swcg_pkg::LEN_RESET;
            coef_fifo.delete();
            failures <= 0;
            outstanding <= 0;
            checked <= 0;
            flagged <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == 1'(swcg_pkg::REG_TYPE))
                    shape <= swcg_pkg::window_type_t'(cfg_data[1:0]);
                else
                    points <= cfg_data;
            end
            if (sample_valid && !sample_stall)
            begin
                coef_fifo = {coef_fifo, window_coef(sample_index)};
            end
            if (result_valid && !result_stall)
            begin
                if (coef_fifo.size() == 0)
                begin
                    $error("unexpected result: coefficient=%0d index_out_of_range=%0b",
                           coefficient, index_out_of_range);
                    errs++;
                end
                else
                begin
                    want = coef_fifo.pop_front();
                    checked <= checked + 1;
                    flagged <= flagged + int'(index_out_of_range);
                    if (coefficient !== want.coef)
                    begin
                        $error("coefficient: expected %0d, got %0d", want.coef, coefficient);
                        errs++;
                    end
                    if (index_out_of_range !== want.oor)
                    begin
                        $error("index_out_of_range: expected %0b, got %0b",
                               want.oor, index_out_of_range);
                        errs++;
                    end
                end
            end
            failures <= failures + errs;
            outstanding <= coef_fifo.size();
        end
    end

endmodule

>>> tb/testbench.sv
// Top of the window generator bench: clock, reset, register phases, sample traffic
// and result back-pressure. Depends on swcg_pkg, the block and swcg_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int DRAIN_CYCLES = 40;     // extra wait after the scoreboard has emptied
    localparam int IDLE_LIMIT   = 5000;   // longest legal silence is the long hold-off
    localparam int LONG_HOLD    = 300;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_write = 1'b0;
    logic                          cfg_index = 1'b0;
    logic [swcg_pkg::LEN_W-1:0]    cfg_data = '0;
    logic                          sample_valid = 1'b0;
    logic                          sample_stall;
    logic [15:0]                   sample_index = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    logic [swcg_pkg::COEF_W-1:0]   coefficient;
    logic                          index_out_of_range;

    int failures;
    int outstanding;
    int checked;
    int flagged;
    int stall_style = 0;
    bit hold_request = 1'b0;
    bit hold_served = 1'b0;
    int idle_cycles = 0;

    always #5 clk = ~clk;

    spectral_window_coefficient_generator uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .sample_valid       (sample_valid),
        .sample_stall       (sample_stall),
        .sample_index       (sample_index),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .coefficient        (coefficient),
        .index_out_of_range (index_out_of_range)
    );

    swcg_checker scoreboard (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .sample_valid       (sample_valid),
        .sample_stall       (sample_stall),
        .sample_index       (sample_index),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .coefficient        (coefficient),
        .index_out_of_range (index_out_of_range),
        .failures           (failures),
        .outstanding        (outstanding),
        .checked            (checked),
        .flagged            (flagged)
    );

    // Watchdog: end the run if neither channel has a transfer for too long
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("spectral_window_coefficient_generator: mismatch");
            $finish;
        end
    end

    // Result back-pressure. A long hold-off, when requested, lets the pipeline fill
    // up so the block has to raise sample_stall; otherwise follow the current style.
    initial
    begin
        int phase_cnt;
        phase_cnt = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            phase_cnt++;
            if (hold_request && !hold_served)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                result_stall <= 1'b0;
                hold_served = 1'b1;
            end
            else
            begin
                case (stall_style)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 3) == 0);
                    2: result_stall <= $urandom_range(0, 1);
                    default: result_stall <= (phase_cnt % 7) < 3;   // regular pattern
                endcase
            end
        end
    end

    task automatic write_reg(input logic reg_sel, input logic [swcg_pkg::LEN_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= reg_sel;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Offer one index and hold it until the transfer happens
    task automatic offer_index(input logic [15:0] n);
        sample_valid <= 1'b1;
        sample_index <= n;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
    endtask

    // Drop valid for a random gap now and then, keep it up within a burst
    task automatic maybe_gap(inout int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (outstanding != 0 || (result_valid === 1'b1))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        swcg_pkg::window_type_t     shapes [4];
        logic [swcg_pkg::LEN_W-1:0] lengths [10];
        logic [swcg_pkg::LEN_W-1:0] len;
        logic [15:0]                top_index;
        int                         burst_left;
        int                         phase;
        shapes = '{swcg_pkg::WIN_RECT, swcg_pkg::WIN_HANN, swcg_pkg::WIN_HAMMING,
                   swcg_pkg::WIN_BLACKMAN};
        lengths = '{17'd1024, 17'd1, 17'd2, 17'd3, 17'd65536,
                    17'd65537, 17'd131071, 17'd0, 17'd7, 17'd255};
        burst_left = 0;
        phase = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults first: Hann over 1024 points, with its edges, the midpoint and two out-of-range indices
        offer_index(16'd0);
        offer_index(16'd511);
        offer_index(16'd1023);
        offer_index(16'd1024);
        offer_index(16'hFFFF);
        sample_valid <= 1'b0;
        wait_drained();

        foreach (shapes[s])
        begin
            foreach (lengths[l])
            begin
                // two phases (Hamming and Blackman) use a random length in place of the last list entry
                len = (l == 9 && s > 1) ? swcg_pkg::LEN_W'($urandom_range(4, 5000))
                                        : lengths[l];
                write_reg(1'(swcg_pkg::REG_TYPE), swcg_pkg::LEN_W'(shapes[s]));
                write_reg(1'(swcg_pkg::REG_LENGTH), len);
                stall_style = phase % 4;
                if (phase == 13)
                    hold_request = 1'b1;
                phase++;

                // Edges of the window and index len (out of range whenever len fits in 16 bits)
                offer_index(16'd0);
                offer_index(16'(len - 1));
                offer_index(16'(len));

                top_index = (len == 0) ? 16'hFFFF
                          : (len > 65536) ? 16'hFFFF : 16'(len - 1);
                repeat (47)
                begin
                    maybe_gap(burst_left);
                    if ($urandom_range(0, 6) == 0)
                        offer_index(16'($urandom));
                    else
                        offer_index(16'($urandom_range(0, top_index)));
                end
                sample_valid <= 1'b0;
                wait_drained();
            end
        end

        // Leave the block with a Blackman window and no idling at all
        write_reg(1'(swcg_pkg::REG_TYPE), swcg_pkg::LEN_W'(swcg_pkg::WIN_BLACKMAN));
        write_reg(1'(swcg_pkg::REG_LENGTH), 17'd4096);
        stall_style = 0;
        repeat (60)
            offer_index(16'($urandom_range(0, 4095)));
        sample_valid <= 1'b0;
        wait_drained();

        $display("Covered all four window shapes in %0d shape/length phases, lengths 0, 1, 2,",
                 phase);
        $display("65536 and above; %0d coefficients checked, %0d out of range.",
                 checked, flagged);
        if (failures == 0)
            $display("spectral_window_coefficient_generator: match");
        else
            $display("spectral_window_coefficient_generator: mismatch");
        $finish;
    end

endmodule

>>> spectral_window_coefficient_generator.f
rtl/swcg_pkg.sv
rtl/swcg_phase_div.sv
rtl/swcg_cos_rom.sv
rtl/swcg_cos_lookup.sv
rtl/spectral_window_coefficient_generator.sv
tb/swcg_checker.sv
tb/testbench.sv
